// ----- rtl/core/dgr_pkg.sv -----
// Shared types and constants of the directed graph edge store.
package dgr_pkg;

    localparam int OP_W   = 3;
    localparam int NODE_W = 5;
    localparam int CNT_W  = 6;

    localparam logic [CNT_W-1:0] CNT_RESET = 6'd32;

    localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
    localparam logic [OP_W-1:0] OP_HAS_EDGE = 3'd2;
    localparam logic [OP_W-1:0] OP_HAS_PATH = 3'd3;
    localparam logic [OP_W-1:0] OP_REVERSAL = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_USE,
        S_WALK,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load_item;
        logic rd_item;
        logic exec;
        logic walk;
        logic fin_walk;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic walk_op;
        logic walk_idle;
        logic out_full;
    } t_sts;

endpackage

// ----- rtl/core/dgr_if.sv -----
// Valid/ready channel interfaces for request and result items.
interface dgr_in_if;
    logic                        valid;
    logic                        ready;
    logic [dgr_pkg::OP_W-1:0]    op;
    logic [dgr_pkg::NODE_W-1:0]  source_node;
    logic [dgr_pkg::NODE_W-1:0]  target_node;

    modport source (output valid, op, source_node, target_node, input ready);
    modport sink (input valid, op, source_node, target_node, output ready);
endinterface

interface dgr_out_if;
    logic valid;
    logic ready;
    logic answer;
    logic error;

    modport source (output valid, answer, error, input ready);
    modport sink (input valid, answer, error, output ready);
endinterface

// ----- rtl/core/dgr_ctrl.sv -----
// Control state machine that sequences each item through the datapath.
module dgr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dgr_pkg::t_sts i_sts,
    output dgr_pkg::t_cmd o_cmd
);

    dgr_pkg::t_state r_state;
    dgr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dgr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            dgr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = dgr_pkg::S_READ;
                end
            end
            dgr_pkg::S_READ: begin
                if (i_sts.bad) begin
                    n_state = dgr_pkg::S_RESP;
                end else begin
                    o_cmd.rd_item = 1'b1;
                    n_state       = dgr_pkg::S_USE;
                end
            end
            dgr_pkg::S_USE: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.walk_op ? dgr_pkg::S_WALK : dgr_pkg::S_RESP;
            end
            dgr_pkg::S_WALK: begin
                if (i_sts.walk_idle) begin
                    o_cmd.fin_walk = 1'b1;
                    n_state        = dgr_pkg::S_RESP;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            dgr_pkg::S_RESP: begin
                if (!i_sts.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = dgr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dgr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/dgr_dp.sv -----
// Datapath with the parent row memory, the walk sets and the output register.
module dgr_dp #(
    parameter int MAX_NODES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dgr_pkg::t_cmd              i_cmd,
    output dgr_pkg::t_sts              o_sts,
    input  logic                       i_cfg_we,
    input  logic [dgr_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  logic [dgr_pkg::OP_W-1:0]   i_op,
    input  logic [dgr_pkg::NODE_W-1:0] i_source_node,
    input  logic [dgr_pkg::NODE_W-1:0] i_target_node,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_answer,
    output logic                       o_error
);

    localparam int NW   = $clog2(MAX_NODES);
    localparam int CW   = $clog2(MAX_NODES + 1);
    localparam int CMPW = (CW > dgr_pkg::CNT_W) ? CW : dgr_pkg::CNT_W;

    logic [dgr_pkg::CNT_W-1:0]  r_node_count;
    logic [dgr_pkg::OP_W-1:0]   r_op;
    logic [dgr_pkg::NODE_W-1:0] r_src;
    logic [dgr_pkg::NODE_W-1:0] r_dst;
    logic                       r_err;
    logic                       r_ans;
    logic [MAX_NODES-1:0]       r_mem [MAX_NODES];
    logic [MAX_NODES-1:0]       r_row_vld;
    logic [MAX_NODES-1:0]       r_rd_data;
    logic                       r_rd_vld;
    logic                       r_rd_busy;
    logic [MAX_NODES-1:0]       r_pending;
    logic [MAX_NODES-1:0]       r_visited;
    logic [MAX_NODES-1:0]       r_reach;
    logic                       r_out_valid;
    logic                       r_out_answer;
    logic                       r_out_error;

    logic [CMPW-1:0]      cnt_lim;
    logic [MAX_NODES-1:0] act_mask;
    logic                 in_err;
    logic [NW-1:0]        src_idx;
    logic [NW-1:0]        dst_idx;
    logic [MAX_NODES-1:0] src_oh;
    logic [MAX_NODES-1:0] dst_oh;
    logic [MAX_NODES-1:0] rd_row;
    logic [MAX_NODES-1:0] row_m;
    logic [NW-1:0]        pick_idx;
    logic [MAX_NODES-1:0] pick_oh;
    logic [MAX_NODES-1:0] new_nodes;
    logic [MAX_NODES-1:0] wr_row;
    logic [MAX_NODES-1:0] rev_start;
    logic [NW-1:0]        rd_addr;
    logic                 rd_en;
    logic                 mem_we;

    always_comb begin
        cnt_lim = (CMPW'(r_node_count) > CMPW'(MAX_NODES)) ? CMPW'(MAX_NODES)
                                                           : CMPW'(r_node_count);
        for (int n = 0; n < MAX_NODES; n++) begin
            act_mask[n] = CMPW'(n) < cnt_lim;
        end
        in_err  = (CMPW'(i_source_node) >= cnt_lim) || (CMPW'(i_target_node) >= cnt_lim);
        src_idx = NW'(r_src);
        dst_idx = NW'(r_dst);
        src_oh  = MAX_NODES'(1) << src_idx;
        dst_oh  = MAX_NODES'(1) << dst_idx;
        rd_row  = r_rd_vld ? r_rd_data : '0;
        row_m   = rd_row & act_mask;
        pick_idx = '0;
        for (int n = MAX_NODES - 1; n >= 0; n--) begin
            if (r_pending[n]) begin
                pick_idx = NW'(n);
            end
        end
        pick_oh   = (|r_pending) ? (MAX_NODES'(1) << pick_idx) : '0;
        new_nodes = r_rd_busy ? (row_m & ~r_visited) : '0;
        wr_row    = (r_op == dgr_pkg::OP_ADD) ? (rd_row | src_oh) : (rd_row & ~src_oh);
        rev_start = row_m & ~src_oh;
        rd_addr   = i_cmd.walk ? pick_idx : dst_idx;
        rd_en     = i_cmd.rd_item || (i_cmd.walk && (|r_pending));
        mem_we    = i_cmd.exec && ((r_op == dgr_pkg::OP_ADD) || (r_op == dgr_pkg::OP_REMOVE));
    end

    assign o_sts.bad       = r_err || (r_op > dgr_pkg::OP_REVERSAL);
    assign o_sts.walk_op   = (r_op == dgr_pkg::OP_HAS_PATH) || (r_op == dgr_pkg::OP_REVERSAL);
    assign o_sts.walk_idle = (r_pending == '0) && !r_rd_busy;
    assign o_sts.out_full  = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= dgr_pkg::CNT_RESET;
            r_row_vld    <= '0;
            r_rd_busy    <= 1'b0;
            r_pending    <= '0;
            r_visited    <= '0;
            r_reach      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            if (mem_we) begin
                r_row_vld[dst_idx] <= 1'b1;
            end
            if (i_cmd.exec) begin
                r_rd_busy <= 1'b0;
                r_reach   <= '0;
                if (r_op == dgr_pkg::OP_HAS_PATH) begin
                    r_pending <= dst_oh;
                    r_visited <= dst_oh;
                end else begin
                    r_pending <= rev_start;
                    r_visited <= rev_start;
                end
            end else if (i_cmd.walk) begin
                r_rd_busy <= |r_pending;
                r_pending <= (r_pending & ~pick_oh) | new_nodes;
                r_visited <= r_visited | new_nodes;
                r_reach   <= r_reach | (r_rd_busy ? row_m : '0);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[dst_idx] <= wr_row;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_row_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op  <= i_op;
            r_src <= i_source_node;
            r_dst <= i_target_node;
            r_err <= in_err;
            r_ans <= 1'b0;
        end else if (i_cmd.exec && (r_op == dgr_pkg::OP_HAS_EDGE)) begin
            r_ans <= rd_row[src_idx];
        end else if (i_cmd.fin_walk) begin
            r_ans <= r_reach[src_idx];
        end
        if (i_cmd.load_out) begin
            r_out_answer <= r_ans;
            r_out_error  <= r_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_answer    = r_out_answer;
    assign o_error     = r_out_error;

`ifndef SYNTHESIS
    a_reach_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_reach & ~r_visited) == '0)
        else $error("Reached node missing from the visited set.");
    a_pending_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending & ~r_visited) == '0)
        else $error("Pending node missing from the visited set.");
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("Output register overwritten before the item was taken.");
`endif

endmodule

// ----- rtl/core/digraph_edge_store_reachability.sv -----
// Top level of the directed graph edge store with reachability queries.
// Requests arrive on i_item (op, source_node, target_node) with valid/ready,
// and each one produces exactly one result item (answer, error) on o_result.
// The node count register is written through i_cfg_we and i_cfg_wdata; the user
// must write it only while the block is idle, as the block does not enforce this.
// It resets to 32, and the count in use is limited to MAX_NODES. One item is
// processed at a time. Out of range requests and unknown ops pass from
// acceptance through the read state straight to the result state; add, remove
// and has_edge read the parent row of the target node and act on it in the
// execute state. Has_path and reversal queries walk backward over the parent
// rows, reading one row per cycle through the single read port of the row
// memory. The next item is accepted in the cycle after a result is loaded,
// even while that result still waits in the output register.
// Reset clears all edges at once through per-row valid bits, so no clearing
// pass is needed. When the receiver stalls, the result holds in the output
// register and a following item stalls only at its own result stage.
module digraph_edge_store_reachability #(
    parameter int MAX_NODES = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    dgr_in_if.sink                    i_item,
    dgr_out_if.source                 o_result,
    input  logic                      i_cfg_we,
    input  logic [dgr_pkg::CNT_W-1:0] i_cfg_wdata
);

    dgr_pkg::t_cmd cmd;
    dgr_pkg::t_sts sts;

    dgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dgr_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_op          (i_item.op),
        .i_source_node (i_item.source_node),
        .i_target_node (i_item.target_node),
        .o_out_valid   (o_result.valid),
        .i_out_ready   (o_result.ready),
        .o_answer      (o_result.answer),
        .o_error       (o_result.error)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the directed graph edge store with reachability queries.
module testbench;

    localparam int OP_BITS   = dgr_pkg::OP_W;
    localparam int NODE_BITS = dgr_pkg::NODE_W;
    localparam int CNT_BITS  = dgr_pkg::CNT_W;

    localparam int NODES         = 32;
    localparam int SETTLE_CYCLES = NODES + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 9;
    localparam int HOLD_PHASE    = 3;
    localparam int CALM_PHASE    = PHASES - 1;
    localparam int PLAN_ROWS     = 29;

    localparam logic [OP_BITS-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_BITS-1:0] OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic answer;
        logic error;
    } t_reply;

    typedef enum logic {
        ROW_ITEM,
        ROW_COUNT
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CNT_BITS-1:0]  count;
        logic [OP_BITS-1:0]   op;
        logic [NODE_BITS-1:0] src;
        logic [NODE_BITS-1:0] dst;
        logic                 typed;
        t_reply               reply;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CNT_BITS-1:0] i_cfg_wdata;

    dgr_in_if  item_if ();
    dgr_out_if result_if ();

    digraph_edge_store_reachability u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_result    (result_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    logic [NODES-1:0]    in_edges [NODES];
    logic [CNT_BITS-1:0] node_limit;
    t_reply              pending_replies [$];

    int  fails;
    int  items_sent;
    int  replies_checked;
    int  walks;
    int  walks_found;
    int  settings_used;
    int  cycles;
    bit  calm;
    bit  hold_request;

    logic [CNT_BITS-1:0] phase_count [PHASES] =
        '{6'd32, 6'd5, 6'd1, 6'd32, 6'd12, 6'd0, 6'd63, 6'd2, 6'd32};
    int phase_len [PHASES] = '{300, 150, 40, 200, 150, 20, 150, 60, 230};

    t_plan_row plan [PLAN_ROWS];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, pending_replies.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic logic ancestors_reach(input logic [NODES-1:0] seeds,
                                             input logic [NODE_BITS-1:0] src, input int cnt);
        logic [NODES-1:0] mask;
        logic [NODES-1:0] seen;
        logic [NODES-1:0] found;
        mask  = (cnt >= NODES) ? '1 : ((NODES'(1) << cnt) - 1'b1);
        seen  = seeds & mask;
        found = '0;
        for (int pass = 0; pass <= NODES; pass++) begin
            for (int v = 0; v < cnt; v++) begin
                if (seen[v]) begin
                    found |= in_edges[v];
                end
            end
            found &= mask;
            seen  |= found;
        end
        return found[src];
    endfunction

    function automatic t_reply predict_reply(input logic [OP_BITS-1:0] op,
                                             input logic [NODE_BITS-1:0] src,
                                             input logic [NODE_BITS-1:0] dst);
        t_reply           r;
        int               cnt;
        logic [NODES-1:0] seeds;
        cnt = (node_limit > NODES) ? NODES : int'(node_limit);
        r   = '0;
        if (src >= cnt || dst >= cnt) begin
            r.error = 1'b1;
            return r;
        end
        case (op)
            dgr_pkg::OP_ADD: begin
                in_edges[dst][src] = 1'b1;
            end
            dgr_pkg::OP_REMOVE: begin
                in_edges[dst][src] = 1'b0;
            end
            dgr_pkg::OP_HAS_EDGE: begin
                r.answer = in_edges[dst][src];
            end
            dgr_pkg::OP_HAS_PATH: begin
                seeds      = '0;
                seeds[dst] = 1'b1;
                r.answer   = ancestors_reach(seeds, src, cnt);
            end
            dgr_pkg::OP_REVERSAL: begin
                seeds      = in_edges[dst];
                seeds[src] = 1'b0;
                r.answer   = ancestors_reach(seeds, src, cnt);
            end
            default: begin
            end
        endcase
        if (op == dgr_pkg::OP_HAS_PATH || op == dgr_pkg::OP_REVERSAL) begin
            walks++;
            walks_found += r.answer;
        end
        return r;
    endfunction

    function automatic t_plan_row item_row(input logic [OP_BITS-1:0] op,
                                           input logic [NODE_BITS-1:0] src,
                                           input logic [NODE_BITS-1:0] dst,
                                           input logic typed, input logic answer,
                                           input logic error);
        t_plan_row row;
        row       = '0;
        row.kind  = ROW_ITEM;
        row.op    = op;
        row.src   = src;
        row.dst   = dst;
        row.typed = typed;
        row.reply = '{answer: answer, error: error};
        return row;
    endfunction

    function automatic t_plan_row count_row(input logic [CNT_BITS-1:0] count);
        t_plan_row row;
        row       = '0;
        row.kind  = ROW_COUNT;
        row.count = count;
        return row;
    endfunction

    task automatic check_reply(input logic answer, input logic error);
        t_reply want;
        if (pending_replies.size() == 0) begin
            if (fails < 10) begin
                $display("Unexpected result: answer=%0b error=%0b", answer, error);
            end
            fails++;
        end else begin
            want = pending_replies.pop_front();
            replies_checked++;
            if (answer !== want.answer || error !== want.error) begin
                if (fails < 10) begin
                    $display("Mismatch on result %0d: expected answer=%0b error=%0b,",
                             replies_checked, want.answer, want.error);
                    $display("    got answer=%0b error=%0b", answer, error);
                end
                fails++;
            end
        end
    endtask

    initial begin : result_sink
        int stall_left;
        int hold_left;
        bit rdy;
        stall_left      = 0;
        hold_left       = 0;
        result_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_if.valid && result_if.ready) begin
                check_reply(result_if.answer, result_if.error);
            end
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 7);
                rdy        = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            result_if.ready <= rdy;
        end
    end

    task automatic offer_request(input logic [OP_BITS-1:0] op,
                                 input logic [NODE_BITS-1:0] src,
                                 input logic [NODE_BITS-1:0] dst, input logic typed,
                                 input t_reply typed_reply);
        t_reply predicted;
        if (!calm && $urandom_range(0, 7) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        item_if.valid       <= 1'b1;
        item_if.op          <= op;
        item_if.source_node <= src;
        item_if.target_node <= dst;
        do @(posedge i_clk); while (!item_if.ready);
        predicted = predict_reply(op, src, dst);
        pending_replies.push_back(typed ? typed_reply : predicted);
        items_sent++;
    endtask

    task automatic drain_results();
        item_if.valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_node_count(input logic [CNT_BITS-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        node_limit  = value;
        settings_used++;
    endtask

    task automatic offer_random(input int cnt);
        logic [OP_BITS-1:0]   op;
        logic [NODE_BITS-1:0] src;
        logic [NODE_BITS-1:0] dst;
        int                   pick;
        t_reply               none;
        none = '0;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            op = dgr_pkg::OP_ADD;
        end else if (pick < 48) begin
            op = dgr_pkg::OP_REMOVE;
        end else if (pick < 60) begin
            op = dgr_pkg::OP_HAS_EDGE;
        end else if (pick < 78) begin
            op = dgr_pkg::OP_HAS_PATH;
        end else if (pick < 95) begin
            op = dgr_pkg::OP_REVERSAL;
        end else begin
            op = OP_BITS'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        if (cnt > 0 && $urandom_range(0, 9) != 0) begin
            src = NODE_BITS'($urandom_range(0, cnt - 1));
            dst = NODE_BITS'($urandom_range(0, cnt - 1));
        end else begin
            src = NODE_BITS'($urandom_range(0, NODES - 1));
            dst = NODE_BITS'($urandom_range(0, NODES - 1));
        end
        offer_request(op, src, dst, 1'b0, none);
    endtask

    initial begin
        int eff;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        item_if.valid       = 1'b0;
        item_if.op          = dgr_pkg::OP_ADD;
        item_if.source_node = '0;
        item_if.target_node = '0;
        fails               = 0;
        items_sent          = 0;
        replies_checked     = 0;
        walks               = 0;
        walks_found         = 0;
        settings_used       = 0;
        cycles              = 0;
        calm                = 1'b0;
        hold_request        = 1'b0;
        node_limit          = dgr_pkg::CNT_RESET;
        for (int t = 0; t < NODES; t++) begin
            in_edges[t] = '0;
        end

        plan = '{
            item_row(dgr_pkg::OP_HAS_EDGE, 5'd0, 5'd0, 1'b1, 1'b0, 1'b0),
            item_row(dgr_pkg::OP_HAS_PATH, 5'd31, 5'd0, 1'b1, 1'b0, 1'b0),
            item_row(dgr_pkg::OP_ADD, 5'd0, 5'd31, 1'b1, 1'b0, 1'b0),
            item_row(dgr_pkg::OP_ADD, 5'd0, 5'd31, 1'b1, 1'b0, 1'b0),
            item_row(dgr_pkg::OP_HAS_EDGE, 5'd0, 5'd31, 1'b1, 1'b1, 1'b0),
            item_row(dgr_pkg::OP_ADD, 5'd31, 5'd5, 1'b1, 1'b0, 1'b0),
            item_row(dgr_pkg::OP_ADD, 5'd0, 5'd5, 1'b1, 1'b0, 1'b0),
            item_row(dgr_pkg::OP_HAS_PATH, 5'd0, 5'd5, 1'b0, 1'b0, 1'b0),
            item_row(dgr_pkg::OP_REVERSAL, 5'd0, 5'd31, 1'b0, 1'b0, 1'b0),
            item_row(dgr_pkg::OP_REVERSAL, 5'd0, 5'd5, 1'b0, 1'b0, 1'b0),
            item_row(dgr_pkg::OP_ADD, 5'd5, 5'd0, 1'b1, 1'b0, 1'b0),
            item_row(dgr_pkg::OP_HAS_PATH, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0),
            item_row(dgr_pkg::OP_ADD, 5'd7, 5'd7, 1'b1, 1'b0, 1'b0),
            item_row(dgr_pkg::OP_HAS_PATH, 5'd7, 5'd7, 1'b0, 1'b0, 1'b0),
            item_row(dgr_pkg::OP_REVERSAL, 5'd7, 5'd7, 1'b0, 1'b0, 1'b0),
            item_row(dgr_pkg::OP_REMOVE, 5'd0, 5'd31, 1'b1, 1'b0, 1'b0),
            item_row(dgr_pkg::OP_HAS_EDGE, 5'd0, 5'd31, 1'b1, 1'b0, 1'b0),
            item_row(OP_UNUSED_LO, 5'd3, 5'd4, 1'b1, 1'b0, 1'b0),
            item_row(OP_UNUSED_HI, 5'd31, 5'd31, 1'b1, 1'b0, 1'b0),
            count_row(6'd6),
            item_row(dgr_pkg::OP_HAS_PATH, 5'd31, 5'd5, 1'b1, 1'b0, 1'b1),
            item_row(dgr_pkg::OP_HAS_PATH, 5'd0, 5'd5, 1'b0, 1'b0, 1'b0),
            count_row(6'd1),
            item_row(dgr_pkg::OP_ADD, 5'd1, 5'd0, 1'b1, 1'b0, 1'b1),
            item_row(dgr_pkg::OP_HAS_EDGE, 5'd0, 5'd0, 1'b1, 1'b0, 1'b0),
            count_row(6'd0),
            item_row(dgr_pkg::OP_ADD, 5'd0, 5'd0, 1'b1, 1'b0, 1'b1),
            count_row(6'd63),
            item_row(dgr_pkg::OP_REVERSAL, 5'd0, 5'd5, 1'b0, 1'b0, 1'b0)
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_COUNT) begin
                set_node_count(plan[r].count);
            end else begin
                offer_request(plan[r].op, plan[r].src, plan[r].dst, plan[r].typed,
                              plan[r].reply);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            set_node_count(phase_count[p]);
            eff  = (phase_count[p] > NODES) ? NODES : int'(phase_count[p]);
            calm = (p == CALM_PHASE);
            for (int k = 0; k < phase_len[p]; k++) begin
                if (p == 0 && k == phase_len[p] / 2) begin
                    drain_results();
                end
                if (p == HOLD_PHASE && k == 20) begin
                    hold_request = 1'b1;
                end
                offer_random(eff);
            end
        end

        drain_results();
        $display("Sent %0d items across %0d node-count settings, checked %0d results.",
                 items_sent, settings_used, replies_checked);
        $display("Reachability queries: %0d, of which %0d found a path.", walks, walks_found);
        if (fails == 0 && pending_replies.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
